@@ design/cls_pkg.sv @@
// shared types, constants and the permutation table of the solver
`default_nettype none
package cls_pkg;

    localparam int MAX_SIZE  = 4;
    localparam int COLS      = MAX_SIZE + 1;
    localparam int MAT_DEPTH = MAX_SIZE * COLS;
    localparam int ADDR_W    = $clog2(MAT_DEPTH);
    localparam int NPERM     = 24;
    localparam int ACC_W     = 160;
    localparam int REM_W     = 136;

    // one classified input item on its way to the solver core
    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
        logic              last;
    } cls_item_t;

    // column picked in each row, row 0 in the low bits
    localparam logic [7:0] PERM_COLS [NPERM] = '{
        {2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0},
        {2'd3, 2'd1, 2'd2, 2'd0}, {2'd1, 2'd3, 2'd2, 2'd0},
        {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
        {2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1},
        {2'd3, 2'd0, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1},
        {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
        {2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2},
        {2'd3, 2'd0, 2'd1, 2'd2}, {2'd0, 2'd3, 2'd1, 2'd2},
        {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
        {2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3},
        {2'd2, 2'd0, 2'd1, 2'd3}, {2'd0, 2'd2, 2'd1, 2'd3},
        {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
    };

    // odd permutations
    localparam logic [NPERM-1:0] PERM_ODD = 24'h666666;

endpackage
`default_nettype wire

@@ design/cls_front.sv @@
// input side: range check of each item and a short queue toward the core
`default_nettype none
module cls_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [39:0]       s_tdata,   // row_index, column_index, element_value, pad
    input  wire logic              s_tlast,
    output logic                   q_valid,
    output cls_pkg::cls_item_t     q_item,
    input  wire logic              q_pop
);
    import cls_pkg::*;

    localparam int QD = 4;

    cls_item_t  q_mem_reg [QD];
    logic [1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       push;
    cls_item_t  item;
    logic [1:0] row;
    logic [2:0] col;

    // classify: out-of-range positions keep only the last mark
    always_comb begin
        row       = s_tdata[1:0];
        col       = s_tdata[4:2];
        item.wr   = (col <= 3'(MAX_SIZE));
        item.addr = ADDR_W'(({3'd0, row} << 2) + {3'd0, row} + {2'd0, col});
        item.data = s_tdata[36:5];
        item.last = s_tlast;
    end

    assign s_tready = (cnt_reg != 3'(QD));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 3'd0);
    assign q_item   = q_mem_reg[rptr_reg];

    // pointer and fill count
    always_comb begin
        wptr_next = push ? wptr_reg + 2'd1 : wptr_reg;
        rptr_next = q_pop ? rptr_reg + 2'd1 : rptr_reg;
        cnt_next  = cnt_reg + {2'd0, push} - {2'd0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wptr_reg] <= item;
        end
    end

endmodule
`default_nettype wire

@@ design/cls_back.sv @@
// solver core: matrix store, permutation determinant engine, divider, result register
`default_nettype none
module cls_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [2:0]        size_in_use,
    input  wire logic              q_valid,
    input  wire cls_pkg::cls_item_t q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,   // unknown_index, solution_value, pad
    output logic                   m_tuser,   // singular
    output logic                   m_tlast
);
    import cls_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PSTART = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_LOAD   = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_ACC    = 4'd5;
    localparam logic [3:0] S_DETEND = 4'd6;
    localparam logic [3:0] S_DIVP   = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [31:0]        mem [MAT_DEPTH];
    logic [3:0]         state_reg;
    logic [2:0]         n_reg;
    logic [1:0]         k_reg;
    logic               main_reg, sing_reg;
    logic [4:0]         perm_reg;
    logic [1:0]         fac_reg, limb_reg;
    logic [31:0]        rd_data_reg, mag_reg, carry_reg;
    logic               pad_reg, pad_one_reg, term_neg_reg;
    logic [127:0]       prod_reg;
    logic [ACC_W-1:0]   acc_reg, dmain_reg, dvd_reg;
    logic [REM_W-1:0]   rem_reg, den_reg;
    logic [31:0]        q_reg;
    logic               over_reg, neg_reg;
    logic [7:0]         dcnt_reg;
    logic               out_valid_reg, out_sing_reg, out_last_reg;
    logic [1:0]         out_idx_reg;
    logic [31:0]        out_val_reg;

    logic [2:0]         n_eff;
    logic [1:0]         col_pick;
    logic [2:0]         col_rd;
    logic [ADDR_W-1:0]  rd_addr;
    logic               pad_now;
    logic [31:0]        fac_val;
    logic [63:0]        mul_t;
    logic [ACC_W-1:0]   acc_sum, num_mag, den_mag;
    logic [REM_W-1:0]   rem_sh;
    logic               qbit;
    logic [31:0]        limit, sat_mag, sat_val;
    logic               out_free;

    // effective size, clamped to 1..MAX_SIZE
    always_comb begin
        n_eff = size_in_use;
        if (size_in_use == 3'd0) begin
            n_eff = 3'd1;
        end else if (size_in_use > 3'(MAX_SIZE)) begin
            n_eff = 3'(MAX_SIZE);
        end
    end

    // element address; rows and columns past n act as identity padding
    always_comb begin
        col_pick = PERM_COLS[perm_reg][2*fac_reg +: 2];
        pad_now  = ({1'b0, fac_reg} >= n_reg) || ({1'b0, col_pick} >= n_reg);
        col_rd   = (!main_reg && col_pick == k_reg) ? n_reg : {1'b0, col_pick};
        rd_addr  = ADDR_W'(({3'd0, fac_reg} << 2) + {3'd0, fac_reg} + {2'd0, col_rd});
    end

    // factor value, limb multiply and term accumulate
    always_comb begin
        fac_val = pad_reg ? {31'd0, pad_one_reg} : rd_data_reg;
        mul_t   = {32'd0, prod_reg[31:0]} * {32'd0, mag_reg} + {32'd0, carry_reg};
        acc_sum = term_neg_reg ? acc_reg - {32'd0, prod_reg}
                               : acc_reg + {32'd0, prod_reg};
    end

    // divider step and operand magnitudes
    always_comb begin
        num_mag = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
        den_mag = dmain_reg[ACC_W-1] ? -dmain_reg : dmain_reg;
        rem_sh  = {rem_reg[REM_W-2:0], dvd_reg[ACC_W-1]};
        qbit    = (rem_sh >= den_reg);
    end

    // truncated quotient saturated to the signed 32-bit range
    always_comb begin
        limit   = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat_mag = (over_reg || q_reg > limit) ? limit : q_reg;
        sat_val = neg_reg ? -sat_mag : sat_mag;
    end

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready && state_reg != S_EMIT) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_item.last) begin
                        n_reg     <= n_eff;
                        main_reg  <= 1'b1;
                        k_reg     <= 2'd0;
                        perm_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_PSTART;
                    end
                end
                S_PSTART: begin
                    prod_reg     <= 128'd1;
                    fac_reg      <= 2'd0;
                    term_neg_reg <= PERM_ODD[perm_reg];
                    state_reg    <= S_READ;
                end
                S_READ: begin
                    pad_reg     <= pad_now;
                    pad_one_reg <= ({1'b0, fac_reg} >= n_reg) && (col_pick == fac_reg);
                    state_reg   <= S_LOAD;
                end
                S_LOAD: begin
                    mag_reg      <= fac_val[31] ? -fac_val : fac_val;
                    term_neg_reg <= term_neg_reg ^ fac_val[31];
                    limb_reg     <= 2'd0;
                    carry_reg    <= '0;
                    state_reg    <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= {mul_t[31:0], prod_reg[127:32]};
                    carry_reg <= mul_t[63:32];
                    limb_reg  <= limb_reg + 2'd1;
                    if (limb_reg == 2'd3) begin
                        if (fac_reg == 2'(MAX_SIZE - 1)) begin
                            state_reg <= S_ACC;
                        end else begin
                            fac_reg   <= fac_reg + 2'd1;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_ACC: begin
                    acc_reg <= acc_sum;
                    if (perm_reg == 5'(NPERM - 1)) begin
                        state_reg <= S_DETEND;
                    end else begin
                        perm_reg  <= perm_reg + 5'd1;
                        state_reg <= S_PSTART;
                    end
                end
                S_DETEND: begin
                    if (main_reg) begin
                        dmain_reg <= acc_reg;
                        sing_reg  <= (acc_reg == '0);
                        main_reg  <= 1'b0;
                        acc_reg   <= '0;
                        perm_reg  <= '0;
                        if (acc_reg == '0) begin
                            q_reg     <= '0;
                            over_reg  <= 1'b0;
                            neg_reg   <= 1'b0;
                            state_reg <= S_EMIT;
                        end else begin
                            state_reg <= S_PSTART;
                        end
                    end else begin
                        state_reg <= S_DIVP;
                    end
                end
                S_DIVP: begin
                    neg_reg   <= acc_reg[ACC_W-1] ^ dmain_reg[ACC_W-1];
                    dvd_reg   <= num_mag << 16;
                    den_reg   <= den_mag[REM_W-1:0];
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    over_reg  <= 1'b0;
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg  <= qbit ? rem_sh - den_reg : rem_sh;
                    dvd_reg  <= dvd_reg << 1;
                    q_reg    <= {q_reg[30:0], qbit};
                    over_reg <= over_reg | q_reg[31];
                    dcnt_reg <= dcnt_reg + 8'd1;
                    if (dcnt_reg == 8'(ACC_W - 1)) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= k_reg;
                        out_val_reg   <= sat_val;
                        out_sing_reg  <= sing_reg;
                        out_last_reg  <= ({1'b0, k_reg} == n_reg - 3'd1);
                        if ({1'b0, k_reg} == n_reg - 3'd1) begin
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg    <= k_reg + 2'd1;
                            acc_reg  <= '0;
                            perm_reg <= '0;
                            if (!sing_reg) begin
                                state_reg <= S_PSTART;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // matrix store, one port
    always_ff @(posedge aclk) begin
        if (q_pop && q_item.wr) begin
            mem[q_item.addr] <= q_item.data;
        end
        if (state_reg == S_READ) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_val_reg, out_idx_reg};
    assign m_tuser  = out_sing_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[33:2] == 32'd0)
        else $error("singular result carries a nonzero value");
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> {1'b0, m_tdata[1:0]} == n_reg - 3'd1)
        else $error("last mark on the wrong unknown");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == S_IDLE)
        else $error("queue popped during a solve");
    a_carry_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL && limb_reg == 2'd3 |=> carry_reg == 32'd0)
        else $error("product overflowed its limbs");
`endif

endmodule
`default_nettype wire

@@ design/cramer_linear_solver.sv @@
// top level of the Cramer's rule solver: size register, input queue and solver core
//
// Input channel s_*: one matrix element per item, row in s_tdata[1:0], column in
// s_tdata[4:2] (column N is the constant term), Q16.16 value in s_tdata[36:5];
// s_tlast marks the last element and starts the solve. Elements go into a
// 4-deep queue, so the channel takes an item per cycle while the queue has room.
// The core drains the queue into the matrix store while it is idle.
// Each determinant is a sum over the 24 permutations of a 4x4 matrix (smaller
// systems are padded with identity), every term built by a 32-bit limb-serial
// multiplier that reads each factor, takes its magnitude and multiplies it into
// the four 32-bit limbs of the product. Each unknown then takes a 160-step
// restoring divider. A singular system stops after the first determinant and
// gives N zero results flagged in m_tuser.
// Output channel m_*: unknown index in m_tdata[1:0], value in m_tdata[33:2],
// m_tlast on the final unknown. Results sit in an output register; a stalled
// receiver holds the core, while the input queue keeps filling.
// Reset clears the queue, the core state and sets the size register to 4;
// matrix content is undefined until written.
`default_nettype none
module cramer_linear_solver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data,   // size_in_use
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,    // row_index, column_index, element_value, pad
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,    // unknown_index, solution_value, pad
    output logic             m_tuser,    // singular
    output logic             m_tlast
);
    import cls_pkg::*;

    logic [2:0] size_reg;
    logic       q_valid, q_pop;
    cls_item_t  q_item;

    assign cfg_ready = 1'b1;

    // size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= 3'(MAX_SIZE);
        end else if (cfg_valid) begin
            size_reg <= cfg_data;
        end
    end

    cls_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    cls_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .size_in_use (size_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire
